[rtl/core/sll_pkg.sv]
// ----------------------------------------------------------------------------
// sll_pkg
// Types, token kind codes and character classes for the small language lexer.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned SHADOW_W = 40;
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

  // token kinds
  localparam logic [KIND_W-1:0] K_TEXT    = 5'd0;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd1;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd2;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd3;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd4;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd5;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd6;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd7;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd8;
  localparam logic [KIND_W-1:0] K_EQUAL   = 5'd9;
  localparam logic [KIND_W-1:0] K_NOTEQ   = 5'd10;
  localparam logic [KIND_W-1:0] K_LESS    = 5'd11;
  localparam logic [KIND_W-1:0] K_LESSEQ  = 5'd12;
  localparam logic [KIND_W-1:0] K_GREAT   = 5'd13;
  localparam logic [KIND_W-1:0] K_GREATEQ = 5'd14;
  localparam logic [KIND_W-1:0] K_IF      = 5'd15;
  localparam logic [KIND_W-1:0] K_ELSE    = 5'd16;
  localparam logic [KIND_W-1:0] K_END     = 5'd17;
  localparam logic [KIND_W-1:0] K_PRINT   = 5'd18;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd19;
  localparam logic [KIND_W-1:0] K_INT     = 5'd20;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd21;
  localparam logic [KIND_W-1:0] K_EOF     = 5'd22;
  localparam logic [KIND_W-1:0] K_ERR_STR = 5'd23;
  localparam logic [KIND_W-1:0] K_ERR_SYM = 5'd24;

  // keyword images, right aligned in the shadow register
  localparam logic [SHADOW_W-1:0] KW_IF    = {24'd0, "if"};
  localparam logic [SHADOW_W-1:0] KW_ELSE  = {8'd0, "else"};
  localparam logic [SHADOW_W-1:0] KW_END   = {16'd0, "end"};
  localparam logic [SHADOW_W-1:0] KW_PRINT = "print";

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_SYMBOL = 3'd4,
    MODE_DONE   = 3'd5,
    MODE_HALT   = 3'd6
  } mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         text;
    logic [VALUE_W-1:0] value;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic res_t mk_res(input logic [KIND_W-1:0] kind, input logic [7:0] text,
                                  input logic [VALUE_W-1:0] value);
    res_t r;
    r.kind  = kind;
    r.text  = text;
    r.value = value;
    return r;
  endfunction

endpackage

[rtl/core/small_language_lexer_core.sv]
// ----------------------------------------------------------------------------
// small_language_lexer_core
// Streaming lexer: one source byte per input transfer, token items out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries char_byte_i and end_of_input_i.
// Output channel (out_valid_o/out_ready_i) carries kind_o, text_char_o,
// int_value_o and last_o; one token item per transfer.
// An accepted byte is held in the input register, then the scan logic turns
// it into zero to three items that are written together into an output queue
// of OutDepth entries.
// Throughput is one byte per cycle as long as the output side takes one item
// per cycle; a byte is only processed when the queue has room for three
// items, so a long run of multi-item bytes runs at the output rate.
// When the receiver stalls the queue fills and in_ready_o drops; nothing is
// lost. Reset empties the queue and returns the scanner to idle.
// After a stray symbol or unterminated string the block keeps accepting bytes
// but emits nothing until reset; after end of input every byte yields eof.
// ----------------------------------------------------------------------------
module small_language_lexer_core
  import sll_pkg::*;
#(
  parameter int unsigned OutDepth = OUT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_byte_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [KIND_W-1:0]  kind_o,
  output logic [7:0]         text_char_o,
  output logic [VALUE_W-1:0] int_value_o,
  output logic               last_o
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam int unsigned NW   = $clog2(MAX_RES + 1);
  localparam logic [CntW-1:0] Thresh = CntW'(OutDepth - MAX_RES);

  // input register
  logic       v_q;
  logic [7:0] c_q;
  logic       eoi_q;
  logic       proc;

  // scanner state
  mode_e                mode_q, mode_d;
  logic [7:0]           pend_q, pend_d;
  logic [VALUE_W-1:0]   acc_q, acc_d;
  logic [SHADOW_W-1:0]  shadow_q, shadow_d;
  logic [2:0]           wlen_q, wlen_d;

  // results of one byte
  res_t             res [MAX_RES];
  logic [NW-1:0]    n;
  logic             go_on;
  logic [KIND_W-1:0] wkind;
  logic [KIND_W-1:0] sym_kind;
  logic [34:0]      acc_next;

  // output queue
  res_t           fifo_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic           pop;

  assign proc       = v_q && (count_q <= Thresh);
  assign in_ready_o = !v_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      c_q   <= char_byte_i;
      eoi_q <= end_of_input_i;
    end
  end

  always_comb begin
    wkind = K_IDENT;
    if (wlen_q == 3'd2 && shadow_q == KW_IF) wkind = K_IF;
    else if (wlen_q == 3'd4 && shadow_q == KW_ELSE) wkind = K_ELSE;
    else if (wlen_q == 3'd3 && shadow_q == KW_END) wkind = K_END;
    else if (wlen_q == 3'd5 && shadow_q == KW_PRINT) wkind = K_PRINT;
  end

  // acc * 10 + digit as shift-add
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {31'd0, c_q[3:0] - 4'd0};

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    shadow_d = shadow_q;
    wlen_d   = wlen_q;
    n        = '0;
    go_on    = 1'b0;
    sym_kind = K_ASSIGN;
    for (int k = 0; k < MAX_RES; k++) res[k] = '0;

    if (proc) begin
      case (mode_q)
        MODE_HALT: begin
        end
        MODE_DONE: begin
          res[n] = mk_res(K_EOF, 8'd0, '0);
          n = n + 1'b1;
        end
        MODE_WORD: begin
          if (!eoi_q && (is_letter(c_q) || is_digit(c_q))) begin
            if (wlen_q < 3'd5) begin
              shadow_d = {shadow_q[SHADOW_W-9:0], c_q};
              wlen_d   = wlen_q + 3'd1;
            end else begin
              wlen_d = 3'd6;
            end
            res[n] = mk_res(K_TEXT, c_q, '0);
            n = n + 1'b1;
          end else begin
            res[n] = mk_res(wkind, 8'd0, '0);
            n = n + 1'b1;
            go_on = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!eoi_q && is_digit(c_q)) begin
            acc_d = (acc_next > {4'd0, NUM_MAX}) ? NUM_MAX : acc_next[VALUE_W-1:0];
          end else begin
            res[n] = mk_res(K_INT, 8'd0, acc_q);
            n = n + 1'b1;
            go_on = 1'b1;
          end
        end
        MODE_STRING: begin
          if (eoi_q || c_q == 8'h0a) begin
            res[n] = mk_res(K_ERR_STR, 8'd0, '0);
            n = n + 1'b1;
            mode_d = MODE_HALT;
          end else if (c_q == "\"") begin
            res[n] = mk_res(K_STRING, 8'd0, '0);
            n = n + 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            res[n] = mk_res(K_TEXT, c_q, '0);
            n = n + 1'b1;
          end
        end
        MODE_SYMBOL: begin
          if (!eoi_q && c_q == "=") begin
            if (pend_q == "<") sym_kind = K_LESSEQ;
            else if (pend_q == ">") sym_kind = K_GREATEQ;
            else if (pend_q == "!") sym_kind = K_NOTEQ;
            else sym_kind = K_EQUAL;
            res[n] = mk_res(K_TEXT, c_q, '0);
            n = n + 1'b1;
            res[n] = mk_res(sym_kind, 8'd0, '0);
            n = n + 1'b1;
            mode_d = MODE_IDLE;
          end else if (pend_q == "!") begin
            // lone bang
            res[n] = mk_res(K_ERR_SYM, 8'd0, '0);
            n = n + 1'b1;
            mode_d = MODE_HALT;
          end else begin
            if (pend_q == "<") sym_kind = K_LESS;
            else if (pend_q == ">") sym_kind = K_GREAT;
            res[n] = mk_res(sym_kind, 8'd0, '0);
            n = n + 1'b1;
            go_on = 1'b1;
          end
        end
        default: go_on = 1'b1;
      endcase

      if (go_on) begin
        mode_d = MODE_IDLE;
        if (eoi_q) begin
          res[n] = mk_res(K_EOF, 8'd0, '0);
          n = n + 1'b1;
          mode_d = MODE_DONE;
        end else if (is_space(c_q)) begin
        end else if (is_letter(c_q)) begin
          mode_d   = MODE_WORD;
          shadow_d = {32'd0, c_q};
          wlen_d   = 3'd1;
          res[n] = mk_res(K_TEXT, c_q, '0);
          n = n + 1'b1;
        end else if (is_digit(c_q)) begin
          mode_d = MODE_NUMBER;
          acc_d  = {27'd0, c_q[3:0]};
        end else if (c_q == "\"") begin
          mode_d = MODE_STRING;
        end else begin
          res[n] = mk_res(K_TEXT, c_q, '0);
          n = n + 1'b1;
          case (c_q) inside
            "<", ">", "=", "!": begin
              mode_d = MODE_SYMBOL;
              pend_d = c_q;
            end
            "(": begin res[n] = mk_res(K_LPAREN, 8'd0, '0); n = n + 1'b1; end
            ")": begin res[n] = mk_res(K_RPAREN, 8'd0, '0); n = n + 1'b1; end
            "+": begin res[n] = mk_res(K_PLUS, 8'd0, '0); n = n + 1'b1; end
            "-": begin res[n] = mk_res(K_MINUS, 8'd0, '0); n = n + 1'b1; end
            "*": begin res[n] = mk_res(K_STAR, 8'd0, '0); n = n + 1'b1; end
            "/": begin res[n] = mk_res(K_SLASH, 8'd0, '0); n = n + 1'b1; end
            ",": begin res[n] = mk_res(K_COMMA, 8'd0, '0); n = n + 1'b1; end
            default: begin
              // stray byte
              res[n] = mk_res(K_ERR_SYM, 8'd0, '0);
              n = n + 1'b1;
              mode_d = MODE_HALT;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= 8'd0;
      acc_q    <= '0;
      shadow_q <= '0;
      wlen_q   <= 3'd0;
    end else begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      shadow_q <= shadow_d;
      wlen_q   <= wlen_d;
    end
  end

  // output queue
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (NW'(k) < n) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  assign out_valid_o = (count_q != '0);
  assign kind_o      = fifo_q[rd_ptr_q].kind;
  assign text_char_o = fifo_q[rd_ptr_q].text;
  assign int_value_o = fifo_q[rd_ptr_q].value;
  assign last_o      = (fifo_q[rd_ptr_q].kind != K_TEXT);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(OutDepth))
    else $error("output queue overflow");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HALT) |-> (n == '0))
    else $error("items emitted while halted");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DONE) |=> (mode_q == MODE_DONE))
    else $error("left end-of-file mode");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (count_q >= $past(count_q)))
    else $error("queue drained during stall");

endmodule
